### rtl/core/ffp_pkg.sv
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared types, item tables and field checks of the flagged field frame parser.
// ----------------------------------------------------------------------------
package ffp_pkg;

	localparam int DATA_W     = 8;
	localparam int CODE_W     = 5;
	localparam int VALUE_W    = 64;
	localparam int FLAG_BYTES = 3;
	localparam int NUM_ORD    = 21;
	localparam int CFG_IDX_W  = 1;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;
	localparam int QCNT_W     = 3;

	// frame byte positions
	localparam logic [7:0] POS_MAGIC   = 8'd1;
	localparam logic [7:0] POS_VERSION = 8'd2;
	localparam logic [7:0] POS_LENGTH  = 8'd3;
	localparam logic [7:0] POS_FLAG0   = 8'd4;
	localparam logic [7:0] POS_FLAG2   = 8'd6;
	localparam logic [7:0] POS_CONTENT = 8'd7;
	localparam logic [7:0] POS_SAT     = 8'd255;

	localparam logic [7:0] PRINT_LO = 8'd32;
	localparam logic [7:0] PRINT_HI = 8'd126;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'd1;

	localparam logic [7:0] MAGIC_RESET   = 8'hFF;
	localparam logic [2:0] VERSION_RESET = 3'd1;

	// item codes with special handling
	localparam logic [CODE_W-1:0] ITEM_WORD_A     = 5'd1;
	localparam logic [CODE_W-1:0] ITEM_POSITION_A = 5'd2;
	localparam logic [CODE_W-1:0] ITEM_ID_SESSION = 5'd6;
	localparam logic [CODE_W-1:0] ITEM_ID_SERIAL  = 5'd7;
	localparam logic [CODE_W-1:0] ITEM_WORD_B     = 5'd9;
	localparam logic [CODE_W-1:0] ITEM_WORD_C     = 5'd10;
	localparam logic [CODE_W-1:0] ITEM_CODE_BYTE  = 5'd11;
	localparam logic [CODE_W-1:0] ITEM_HEIGHT     = 5'd12;
	localparam logic [CODE_W-1:0] ITEM_SPEED      = 5'd13;
	localparam logic [CODE_W-1:0] ITEM_TRACK      = 5'd14;
	localparam logic [CODE_W-1:0] ITEM_POSITION_B = 5'd15;

	localparam logic [15:0] RAW16_UNKNOWN = 16'hFFFF;
	localparam logic [7:0]  RAW8_UNKNOWN  = 8'hFF;
	localparam logic [15:0] TRACK_MAX     = 16'd3599;
	localparam logic [15:0] SPEED_MAX     = 16'd3000;
	localparam logic [15:0] HEIGHT_MIN    = 16'd16000;
	localparam logic [15:0] HEIGHT_MAX    = 16'd38000;
	localparam logic signed [31:0] LAT_LIMIT = 32'sd900000000;
	localparam logic signed [31:0] LON_LIMIT = 32'sd1800000000;

	// field size in bytes by item code
	localparam logic [4:0] ITEM_SIZE [32] = '{
		5'd0, 5'd2, 5'd8, 5'd1, 5'd1, 5'd1, 5'd8, 5'd20,
		5'd0, 5'd2, 5'd2, 5'd1, 5'd2, 5'd2, 5'd2, 5'd8,
		5'd0, 5'd1, 5'd6, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1,
		5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
	};

	// scan order: flag byte 0 bits 7..1, then byte 1, then byte 2
	localparam logic [CODE_W-1:0] ORD_CODE [NUM_ORD] = '{
		5'd7,  5'd6,  5'd5,  5'd4,  5'd3,  5'd2,  5'd1,
		5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd10, 5'd9,
		5'd23, 5'd22, 5'd21, 5'd20, 5'd19, 5'd18, 5'd17
	};

	localparam logic [4:0] CODE_ORD [32] = '{
		5'd0,  5'd6,  5'd5,  5'd4,  5'd3,  5'd2,  5'd1,  5'd0,
		5'd0,  5'd13, 5'd12, 5'd11, 5'd10, 5'd9,  5'd8,  5'd7,
		5'd0,  5'd20, 5'd19, 5'd18, 5'd17, 5'd16, 5'd15, 5'd14,
		5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
	};

	typedef enum logic [1:0] {
		KIND_FIELD   = 2'd0,
		KIND_ID      = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SHORT       = 3'd1,
		ST_MAGIC       = 3'd2,
		ST_VERSION     = 3'd3,
		ST_LENGTH      = 3'd4,
		ST_NO_ITEMS    = 3'd5,
		ST_UNPRINTABLE = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		FAULT_NONE    = 2'd0,
		FAULT_MAGIC   = 2'd2,
		FAULT_VERSION = 2'd3
	} fault_t;

	typedef struct packed {
		logic [7:0] magic;
		logic [2:0] version;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [CODE_W-1:0]  code;
		logic [VALUE_W-1:0] value;
		logic               valid;
		logic [4:0]         idx;
		logic [2:0]         status;
		logic [4:0]         count;
		logic [2:0]         ext;
		logic               stop;
		logic               last;
	} res_t;

	typedef struct packed {
		logic              found;
		logic [CODE_W-1:0] code;
	} sel_t;

	// first flagged item at or after scan position start
	function automatic sel_t select_next(input logic [FLAG_BYTES-1:0][7:0] fl,
			input logic [4:0] start);
		sel_t s;
		s = '0;
		for (int o = NUM_ORD - 1; o >= 0; o--) begin
			if (5'(o) >= start && fl[ORD_CODE[o][4:3]][ORD_CODE[o][2:0]]) begin
				s.found = 1'b1;
				s.code  = ORD_CODE[o];
			end
		end
		return s;
	endfunction

	function automatic logic check_field(input logic [CODE_W-1:0] code,
			input logic [VALUE_W-1:0] v);
		logic [15:0]        r16;
		logic signed [31:0] lon;
		logic signed [31:0] lat;
		logic               ok;
		r16 = v[15:0];
		lon = signed'(v[31:0]);
		lat = signed'(v[63:32]);
		unique case (code)
			ITEM_WORD_A, ITEM_WORD_B, ITEM_WORD_C: ok = r16 != 16'd0 && r16 != RAW16_UNKNOWN;
			ITEM_POSITION_A, ITEM_POSITION_B: ok = lat >= -LAT_LIMIT && lat <= LAT_LIMIT &&
				lon >= -LON_LIMIT && lon <= LON_LIMIT;
			ITEM_TRACK:     ok = r16 <= TRACK_MAX;
			ITEM_SPEED:     ok = r16 <= SPEED_MAX;
			ITEM_HEIGHT:    ok = r16 >= HEIGHT_MIN && r16 <= HEIGHT_MAX;
			ITEM_CODE_BYTE: ok = v[7:0] != RAW8_UNKNOWN;
			default:        ok = 1'b1;
		endcase
		return ok;
	endfunction

endpackage

### rtl/core/ffp_cfg.sv
// ----------------------------------------------------------------------------
// ffp_cfg
// Configuration registers: expected magic byte and accepted major version.
// ----------------------------------------------------------------------------
module ffp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [ffp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffp_pkg::DATA_W-1:0]    cfg_data,
	output ffp_pkg::cfg_t                 cfg
);
	import ffp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic   <= MAGIC_RESET;
			cfg_q.version <= VERSION_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MAGIC:   cfg_q.magic   <= cfg_data;
				REG_VERSION: cfg_q.version <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/ffp_parse.sv
// ----------------------------------------------------------------------------
// ffp_parse
// Frame state and one-pass byte decode: header checks, flagged item scan,
// field assembly and frame summary.
// ----------------------------------------------------------------------------
module ffp_parse (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ffp_pkg::cfg_t              cfg,
	input  logic                       fire,
	input  logic [ffp_pkg::DATA_W-1:0] frame_byte,
	input  logic                       frame_end,
	output logic                       push_a,
	output ffp_pkg::res_t              res_a,
	output logic                       push_b,
	output ffp_pkg::res_t              res_b
);
	import ffp_pkg::*;

	logic [7:0]                  pos_q, pos_n;
	logic [7:0]                  clen_q, clen_n;
	logic [FLAG_BYTES-1:0][7:0]  flags_q, flags_n;
	logic [CODE_W-1:0]           cursor_q, cursor_n;
	logic [4:0]                  seen_q, seen_n;
	logic [VALUE_W-1:0]          acc_q, acc_n, acc_upd;
	logic [7:0]                  coff_q, coff_n;
	logic [4:0]                  items_q, items_n;
	logic                        hdr_q, hdr_n;
	logic                        halt_q, halt_n;
	logic                        idp_q, idp_n;
	logic                        idpr_q, idpr_n;
	logic                        pend_q, pend_n;
	fault_t                      fault_q, fault_n;

	logic                        do_sel;
	logic [4:0]                  sel_start;
	sel_t                        sel;
	logic [4:0]                  sel_size;
	logic                        is_id;
	logic                        printable;
	logic                        ra_valid;
	status_t                     st;
	logic                        done_k;

	always_comb begin
		pos_n     = pos_q;
		clen_n    = clen_q;
		flags_n   = flags_q;
		cursor_n  = cursor_q;
		seen_n    = seen_q;
		acc_n     = acc_q;
		coff_n    = coff_q;
		items_n   = items_q;
		hdr_n     = hdr_q;
		halt_n    = halt_q;
		idp_n     = idp_q;
		idpr_n    = idpr_q;
		pend_n    = pend_q;
		fault_n   = fault_q;
		do_sel    = 1'b0;
		sel_start = '0;
		acc_upd   = acc_q;
		ra_valid  = 1'b0;
		res_a     = '0;
		is_id     = cursor_q == ITEM_ID_SERIAL || cursor_q == ITEM_ID_SESSION;
		printable = frame_byte >= PRINT_LO && frame_byte <= PRINT_HI;

		if (pos_q != POS_SAT) begin
			pos_n = pos_q + 8'd1;
			priority if (pos_q == POS_MAGIC) begin
				hdr_n = frame_byte == cfg.magic;
				if (!hdr_n) fault_n = FAULT_MAGIC;
			end else if (pos_q == POS_VERSION) begin
				if (hdr_q && frame_byte[7:5] != cfg.version) begin
					hdr_n   = 1'b0;
					fault_n = FAULT_VERSION;
				end
			end else if (pos_q == POS_LENGTH) begin
				clen_n = frame_byte;
			end else if (pos_q >= POS_FLAG0 && pos_q <= POS_FLAG2) begin
				// positions 4..6 map to flag bytes 0..2 by their low bits
				flags_n[pos_q[1:0]] = frame_byte;
				if (pos_q == POS_FLAG2 && hdr_q) do_sel = 1'b1;
			end else if (pos_q >= POS_CONTENT && hdr_q && pend_q && !halt_q &&
					coff_q < clen_q) begin
				coff_n = coff_q + 8'd1;
				if (seen_q[4:3] == 2'd0)
					acc_upd = acc_q | (VALUE_W'(frame_byte) << {seen_q[2:0], 3'b000});
				acc_n  = acc_upd;
				seen_n = seen_q + 5'd1;
				if (is_id) begin
					if (cursor_q == ITEM_ID_SERIAL && printable) idpr_n = 1'b1;
					ra_valid    = 1'b1;
					res_a.kind  = KIND_ID;
					res_a.code  = cursor_q;
					res_a.value = VALUE_W'(frame_byte);
					res_a.valid = printable;
					res_a.idx   = seen_q;
				end
				if ({1'b0, seen_q} + 6'd1 >= {1'b0, ITEM_SIZE[cursor_q]}) begin
					if (!is_id) begin
						ra_valid    = 1'b1;
						res_a.kind  = KIND_FIELD;
						res_a.code  = cursor_q;
						res_a.value = acc_upd;
						res_a.valid = check_field(cursor_q, acc_upd);
					end
					if (cursor_q == ITEM_ID_SERIAL) idp_n = 1'b1;
					items_n   = items_q + 5'd1;
					do_sel    = 1'b1;
					sel_start = CODE_ORD[cursor_q] + 5'd1;
				end
			end
		end

		// next flagged item, halting if it would overrun the content length
		sel      = select_next(flags_n, sel_start);
		sel_size = ITEM_SIZE[sel.code];
		if (do_sel) begin
			if (sel.found) begin
				cursor_n = sel.code;
				if ({1'b0, coff_n} + {4'b0, sel_size} > {1'b0, clen_n}) begin
					halt_n = 1'b1;
					pend_n = 1'b0;
				end else begin
					pend_n = 1'b1;
					seen_n = '0;
					acc_n  = '0;
				end
			end else begin
				pend_n = 1'b0;
			end
		end

		res_a.last = !frame_end;

		// frame summary from the state after this byte
		priority if (pos_n < POS_CONTENT)                     st = ST_SHORT;
		else if (fault_n == FAULT_MAGIC)                      st = ST_MAGIC;
		else if (fault_n == FAULT_VERSION || !hdr_n)          st = ST_VERSION;
		else if (clen_n > pos_n - POS_CONTENT)                st = ST_LENGTH;
		else if (idp_n && !idpr_n)                            st = ST_UNPRINTABLE;
		else if (items_n == 5'd0)                             st = ST_NO_ITEMS;
		else                                                  st = ST_OK;

		res_b        = '0;
		res_b.kind   = KIND_SUMMARY;
		res_b.status = st;
		res_b.last   = 1'b1;
		if (st == ST_OK || st == ST_NO_ITEMS || st == ST_UNPRINTABLE)
			res_b.stop = halt_n;
		if (st == ST_OK || st == ST_NO_ITEMS) begin
			res_b.count = items_n;
			for (int k = 0; k < FLAG_BYTES; k++) begin
				done_k = !halt_n || cursor_n[4:3] > 2'(k);
				res_b.ext[k] = done_k && flags_n[k][0];
			end
		end
		done_k = 1'b0;

		if (frame_end) begin
			pos_n    = '0;
			clen_n   = '0;
			flags_n  = '0;
			cursor_n = '0;
			seen_n   = '0;
			acc_n    = '0;
			coff_n   = '0;
			items_n  = '0;
			hdr_n    = 1'b0;
			halt_n   = 1'b0;
			idp_n    = 1'b0;
			idpr_n   = 1'b0;
			pend_n   = 1'b0;
			fault_n  = FAULT_NONE;
		end
	end

	assign push_a = fire && ra_valid;
	assign push_b = fire && frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			clen_q   <= '0;
			flags_q  <= '0;
			cursor_q <= '0;
			seen_q   <= '0;
			acc_q    <= '0;
			coff_q   <= '0;
			items_q  <= '0;
			hdr_q    <= 1'b0;
			halt_q   <= 1'b0;
			idp_q    <= 1'b0;
			idpr_q   <= 1'b0;
			pend_q   <= 1'b0;
			fault_q  <= FAULT_NONE;
		end else if (fire) begin
			pos_q    <= pos_n;
			clen_q   <= clen_n;
			flags_q  <= flags_n;
			cursor_q <= cursor_n;
			seen_q   <= seen_n;
			acc_q    <= acc_n;
			coff_q   <= coff_n;
			items_q  <= items_n;
			hdr_q    <= hdr_n;
			halt_q   <= halt_n;
			idp_q    <= idp_n;
			idpr_q   <= idpr_n;
			pend_q   <= pend_n;
			fault_q  <= fault_n;
		end
	end

endmodule

### rtl/core/ffp_outq.sv
// ----------------------------------------------------------------------------
// ffp_outq
// Result queue: up to two results in a cycle, one out a cycle unless stalled.
// ----------------------------------------------------------------------------
module ffp_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_a,
	input  ffp_pkg::res_t res_a,
	input  logic          push_b,
	input  ffp_pkg::res_t res_b,
	output logic          full,
	output logic          head_valid,
	input  logic          head_stall,
	output ffp_pkg::res_t head
);
	import ffp_pkg::*;

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;
	logic [QPTR_W-1:0] wr_b;

	assign pop  = head_valid && !head_stall;
	assign wr_b = push_a ? wr_q + QPTR_W'(1) : wr_q;

	always_ff @(posedge clk) begin
		if (push_a) mem_q[wr_q] <= res_a;
		if (push_b) mem_q[wr_b] <= res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push_a) + QPTR_W'(push_b);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push_a) + QCNT_W'(push_b) - QCNT_W'(pop);
		end
	end

	// room for two requests is kept whenever input is taken
	assign full       = cnt_q > QCNT_W'(QDEPTH - 2);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

endmodule

### rtl/core/flagged_field_frame_parser.sv
// ----------------------------------------------------------------------------
// flagged_field_frame_parser
// Remote-ID style frame parser: header checks, flag-selected fields, id bytes
// and a per-frame summary.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  frame     | in        | frame_valid/stall      | frame_byte, frame_end
//  result    | out       | result_valid/stall     | result_kind .. run_last
//  cfg       | in        | cfg_wr_en              | cfg_index, cfg_data
//
// one frame byte per cycle unless stalled; results are queued as it is taken
// a final byte may yield two results; the 4-entry result queue drains one
// per cycle unless stalled, and frame_stall rises while over two are queued
// reset clears frame state and the queue and loads magic 0xFF, version 1
// ----------------------------------------------------------------------------
module flagged_field_frame_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          frame_valid,
	output logic                          frame_stall,
	input  logic [7:0]                    frame_byte,
	input  logic                          frame_end,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [1:0]                    result_kind,
	output logic [4:0]                    item_code,
	output logic [63:0]                   field_value,
	output logic                          field_valid,
	output logic [4:0]                    id_byte_index,
	output logic [2:0]                    frame_status,
	output logic [4:0]                    items_count,
	output logic [2:0]                    extension_bits,
	output logic                          stopped_early,
	output logic                          run_last,
	input  logic                          cfg_wr_en,
	input  logic [ffp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffp_pkg::DATA_W-1:0]    cfg_data
);
	import ffp_pkg::*;

	cfg_t cfg;
	logic fire;
	logic push_a;
	logic push_b;
	res_t res_a;
	res_t res_b;
	res_t head;
	logic full;

	assign frame_stall = full;
	assign fire        = frame_valid && !full;

	ffp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ffp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.fire       (fire),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.push_a     (push_a),
		.res_a      (res_a),
		.push_b     (push_b),
		.res_b      (res_b)
	);

	ffp_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_a     (push_a),
		.res_a      (res_a),
		.push_b     (push_b),
		.res_b      (res_b),
		.full       (full),
		.head_valid (result_valid),
		.head_stall (result_stall),
		.head       (head)
	);

	assign result_kind    = head.kind;
	assign item_code      = head.code;
	assign field_value    = head.value;
	assign field_valid    = head.valid;
	assign id_byte_index  = head.idx;
	assign frame_status   = head.status;
	assign items_count    = head.count;
	assign extension_bits = head.ext;
	assign stopped_early  = head.stop;
	assign run_last       = head.last;

endmodule

### rtl/core/ffp_checker.sv
// ----------------------------------------------------------------------------
// ffp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module ffp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  result_kind,
	input logic [4:0]  item_code,
	input logic [63:0] field_value,
	input logic [4:0]  id_byte_index,
	input logic [2:0]  frame_status,
	input logic [4:0]  items_count,
	input logic        run_last
);
	import ffp_pkg::*;

	// a stalled request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_kind) &&
		$stable(item_code) && $stable(field_value) && $stable(run_last))
		else $error("stalled result changed");

	// the frame summary always closes its byte's run
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_SUMMARY |-> run_last && item_code == '0)
		else $error("summary not last of run");

	// status and count belong to summaries only
	a_nonsummary_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind != KIND_SUMMARY |-> frame_status == '0 &&
		items_count == '0)
		else $error("summary fields set on a field result");

	// identifier results carry a single byte of one of the two id items
	a_id_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_ID |-> field_value[63:8] == '0 &&
		id_byte_index <= 5'd19 &&
		(item_code == ITEM_ID_SERIAL || item_code == ITEM_ID_SESSION))
		else $error("malformed identifier byte");

endmodule

bind flagged_field_frame_parser ffp_checker u_ffp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.result_kind   (result_kind),
	.item_code     (item_code),
	.field_value   (field_value),
	.id_byte_index (id_byte_index),
	.frame_status  (frame_status),
	.items_count   (items_count),
	.run_last      (run_last)
);
